>>> design/swarq_pkg.sv
package swarq_pkg;

  localparam int MAX_WINDOW_DEF  = 32;
  localparam int END_REPEATS_DEF = 10;

  localparam int WIN_W = 6;
  localparam int NUM_W = 16;
  localparam int SEQ_W = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_ACK   = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [WIN_W-1:0] WINDOW_RST  = 6'd1;
  localparam logic [NUM_W-1:0] TOTAL_RST   = 16'd1024;
  localparam logic [NUM_W-1:0] TIMEOUT_RST = 16'd1500;

  localparam logic [NUM_W-1:0]        CNT_MAX    = 16'hFFFF;
  localparam logic signed [SEQ_W-1:0] SEQ_END    = -17'sd1;

  typedef struct packed {
    logic [1:0]       action;
    logic [NUM_W-1:0] ack_number;
  } in_item_t;

  typedef struct packed {
    logic signed [SEQ_W-1:0] seq_number;
    logic                    is_retransmit;
    logic [NUM_W-1:0]        retransmit_count;
    logic                    session_done;
    logic                    last;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_ACK,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [NUM_W-1:0] ack;
  } cmd_t;

  typedef struct packed {
    logic [WIN_W-1:0] window_size;
    logic [NUM_W-1:0] total_messages;
    logic [NUM_W-1:0] timeout_ticks;
  } cfg_t;

endpackage

>>> design/swarq_front.sv
module swarq_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  swarq_pkg::in_item_t in_data,
  input  logic               q_ready,
  output logic               q_push,
  output swarq_pkg::cmd_t    q_cmd
);
  import swarq_pkg::*;

  logic known;

  always_comb begin
    known = 1'b1;
    q_cmd.ack = in_data.ack_number;
    q_cmd.kind = CMD_TICK;
    unique case (in_data.action)
      ACT_START: q_cmd.kind = CMD_START;
      ACT_ACK:   q_cmd.kind = CMD_ACK;
      ACT_TICK:  q_cmd.kind = CMD_TICK;
      default:   known = 1'b0;
    endcase
  end

  // drop unused action codes at the door
  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready && known;

endmodule

>>> design/swarq_queue.sv
module swarq_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  swarq_pkg::cmd_t push_cmd,
  output logic            push_ready,
  input  logic            pop,
  output logic            pop_valid,
  output swarq_pkg::cmd_t pop_cmd
);
  import swarq_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  cmd_t              mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]    count_r;

  assign push_ready = (count_r != (PTR_W+1)'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && push_ready) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop && pop_valid) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if ((push && push_ready) && !(pop && pop_valid)) begin
        count_r <= count_r + (PTR_W+1)'(1);
      end else if (!(push && push_ready) && (pop && pop_valid)) begin
        count_r <= count_r - (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> design/swarq_back.sv
module swarq_back #(
  parameter int MAX_WINDOW         = swarq_pkg::MAX_WINDOW_DEF,
  parameter int END_MARKER_REPEATS = swarq_pkg::END_REPEATS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  swarq_pkg::cfg_t     cfg,
  input  logic                q_valid,
  input  swarq_pkg::cmd_t     q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output swarq_pkg::out_item_t out_data
);
  import swarq_pkg::*;

  localparam int IFW   = $clog2(MAX_WINDOW + 1);
  localparam int CNT_W = $clog2(END_MARKER_REPEATS + 1);

  typedef enum logic [1:0] {S_WAIT, S_FILL, S_END, S_RETX} state_t;
  typedef enum logic [1:0] {PH_IDLE, PH_RUN, PH_DONE} phase_t;

  state_t           state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  logic [NUM_W-1:0] base_r, base_nxt;
  logic [IFW-1:0]   inflight_r, inflight_nxt;
  logic [NUM_W-1:0] retry_r, retry_nxt;
  logic [NUM_W-1:0] timer_r, timer_nxt;
  logic [CNT_W-1:0] end_cnt_r, end_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic [WIN_W-1:0] w_eff;
  logic [NUM_W-1:0] limit;
  logic [SEQ_W-1:0] sum_fly;
  logic [SEQ_W-1:0] tick_cnt;
  logic             emit_ok;
  logic             fill_last;
  logic             end_last;

  always_comb begin
    priority if (cfg.window_size == '0) begin
      w_eff = WIN_W'(1);
    end else if (cfg.window_size > WIN_W'(MAX_WINDOW)) begin
      w_eff = WIN_W'(MAX_WINDOW);
    end else begin
      w_eff = cfg.window_size;
    end
  end

  assign limit     = (cfg.timeout_ticks == '0) ? NUM_W'(1) : cfg.timeout_ticks;
  assign sum_fly   = {1'b0, base_r} + SEQ_W'(inflight_r);
  assign tick_cnt  = {1'b0, timer_r} + SEQ_W'(1);
  assign emit_ok   = !out_valid_r || out_ready;
  assign fill_last = (WIN_W'(inflight_r) + WIN_W'(1) >= w_eff) ||
                     (sum_fly + SEQ_W'(1) >= {1'b0, cfg.total_messages});
  assign end_last  = (end_cnt_r == CNT_W'(END_MARKER_REPEATS - 1));

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    base_nxt      = base_r;
    inflight_nxt  = inflight_r;
    retry_nxt     = retry_r;
    timer_nxt     = timer_r;
    end_cnt_nxt   = end_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;

    unique case (state_r)
      S_WAIT: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_cmd.kind)
            CMD_START: begin
              phase_nxt    = PH_RUN;
              base_nxt     = '0;
              inflight_nxt = '0;
              retry_nxt    = '0;
              timer_nxt    = '0;
              state_nxt    = S_FILL;
            end
            CMD_ACK: begin
              if (phase_r == PH_RUN && q_cmd.ack > base_r &&
                  {1'b0, q_cmd.ack} <= sum_fly) begin
                inflight_nxt = inflight_r - IFW'(q_cmd.ack - base_r);
                base_nxt     = q_cmd.ack;
                timer_nxt    = '0;
                state_nxt    = S_FILL;
              end
            end
            CMD_TICK: begin
              if (phase_r == PH_RUN) begin
                if (tick_cnt >= {1'b0, limit}) begin
                  timer_nxt = '0;
                  if (retry_r != CNT_MAX) begin
                    retry_nxt = retry_r + NUM_W'(1);
                  end
                  state_nxt = S_RETX;
                end else begin
                  timer_nxt = tick_cnt[NUM_W-1:0];
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_FILL: begin
        priority if (base_r >= cfg.total_messages) begin
          phase_nxt    = PH_DONE;
          inflight_nxt = '0;
          end_cnt_nxt  = '0;
          state_nxt    = S_END;
        end else if (WIN_W'(inflight_r) < w_eff &&
                     sum_fly < {1'b0, cfg.total_messages}) begin
          if (emit_ok) begin
            out_valid_nxt                 = 1'b1;
            out_data_nxt.seq_number       = sum_fly;
            out_data_nxt.is_retransmit    = 1'b0;
            out_data_nxt.retransmit_count = retry_r;
            out_data_nxt.session_done     = 1'b0;
            out_data_nxt.last             = fill_last;
            inflight_nxt                  = inflight_r + IFW'(1);
            if (fill_last) begin
              state_nxt = S_WAIT;
            end
          end
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_END: begin
        if (emit_ok) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.seq_number       = SEQ_END;
          out_data_nxt.is_retransmit    = 1'b0;
          out_data_nxt.retransmit_count = retry_r;
          out_data_nxt.session_done     = 1'b1;
          out_data_nxt.last             = end_last;
          end_cnt_nxt                   = end_cnt_r + CNT_W'(1);
          if (end_last) begin
            state_nxt = S_WAIT;
          end
        end
      end
      S_RETX: begin
        if (emit_ok) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.seq_number       = {1'b0, base_r};
          out_data_nxt.is_retransmit    = 1'b1;
          out_data_nxt.retransmit_count = retry_r;
          out_data_nxt.session_done     = 1'b0;
          out_data_nxt.last             = 1'b1;
          state_nxt                     = S_WAIT;
        end
      end
      default: state_nxt = S_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WAIT;
      phase_r     <= PH_IDLE;
      base_r      <= '0;
      inflight_r  <= '0;
      retry_r     <= '0;
      timer_r     <= '0;
      end_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      base_r      <= base_nxt;
      inflight_r  <= inflight_nxt;
      retry_r     <= retry_nxt;
      timer_r     <= timer_nxt;
      end_cnt_r   <= end_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> design/sliding_window_arq_sender.sv
// Sliding-window ARQ sender with cumulative acks.
// Input channel (in_valid/in_ready/in_data): start, ack or tick beats. Beats
// with an unused action code are accepted and dropped.
// Result channel (out_valid/out_ready/out_data): one send per beat, with last
// set on the final result caused by an input beat.
// Config port (cfg_we/cfg_index/cfg_data): window size, message total and
// timeout; write only while no work is pending.
// Accepted beats go into a two-entry command queue; the executor pops one
// command per cycle when waiting. A beat's first result is registered after
// the queue entry and the executor's state register (for end markers also
// the end state), then one result per cycle while the receiver is ready: a
// refill emits up to the window size, a timeout one resend, a finished
// session the end markers. The output register holds one result. Ticks short
// of a timeout and ignored acks stay in the waiting state; an advancing ack
// that sends nothing passes the fill state and returns to waiting.
// The queue keeps accepting while the receiver stalls out_ready, until full;
// the executor holds the pending result and waits.
// Reset idles the session and loads the default config registers.
module sliding_window_arq_sender #(
  parameter int MAX_WINDOW         = swarq_pkg::MAX_WINDOW_DEF,
  parameter int END_MARKER_REPEATS = swarq_pkg::END_REPEATS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  swarq_pkg::in_item_t                  in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output swarq_pkg::out_item_t                 out_data,
  input  logic                                 cfg_we,
  input  logic [swarq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swarq_pkg::NUM_W-1:0]          cfg_data
);
  import swarq_pkg::*;

  cfg_t cfg_r;
  logic q_ready, q_push, q_pop, q_valid;
  cmd_t push_cmd, pop_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_size    <= WINDOW_RST;
      cfg_r.total_messages <= TOTAL_RST;
      cfg_r.timeout_ticks  <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW:  cfg_r.window_size    <= cfg_data[WIN_W-1:0];
        CFG_TOTAL:   cfg_r.total_messages <= cfg_data;
        CFG_TIMEOUT: cfg_r.timeout_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  swarq_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  swarq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_cmd    (pop_cmd)
  );

  swarq_back #(
    .MAX_WINDOW         (MAX_WINDOW),
    .END_MARKER_REPEATS (END_MARKER_REPEATS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> design/swarq_checker.sv
module swarq_assertions (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input swarq_pkg::out_item_t            out_data
);
  import swarq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.session_done |->
      out_data.seq_number == SEQ_END && !out_data.is_retransmit)
    else $error("end marker carries a sequence number");

  a_retx_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_retransmit |->
      out_data.last && out_data.seq_number != SEQ_END &&
      out_data.retransmit_count != '0)
    else $error("resend beat malformed");

endmodule

bind sliding_window_arq_sender swarq_assertions u_swarq_assertions (.*);
